// ----- hdl/lmc_pkg.sv -----
// Shared constants, types and the sine table generator for the chorus block.
// No dependencies; used by lfo_modulated_chorus.
`default_nettype none

package lmc_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int RING_DEPTH     = 2048;
   localparam int RING_ADDR_BITS = $clog2(RING_DEPTH);
   localparam int LEN_BITS       = RING_ADDR_BITS + 1;
   localparam int SINE_ADDR_BITS = 10;
   localparam int SINE_SIZE      = 2 ** SINE_ADDR_BITS;
   localparam int SINE_WIDTH     = 16;
   localparam int PHASE_WIDTH    = 32;
   localparam int ACC_BITS       = SAMPLE_WIDTH + 17;

   // Configuration register widths and reset values.
   localparam int RING_LENGTH_BITS = 12;
   localparam int DELAY_SPAN_BITS  = 11;
   localparam int WET_WEIGHT_BITS  = 16;
   localparam int PHASE_STEP_BITS  = 32;
   localparam int CSR_DATA_BITS    = 32;
   localparam int CSR_INDEX_BITS   = 2;

   localparam logic [RING_LENGTH_BITS-1:0] RING_LENGTH_RESET = 12'd1323;
   localparam logic [DELAY_SPAN_BITS-1:0]  DELAY_SPAN_RESET  = 11'd661;
   localparam logic [WET_WEIGHT_BITS-1:0]  WET_WEIGHT_RESET  = 16'd16384;
   localparam logic [PHASE_STEP_BITS-1:0]  PHASE_STEP_RESET  = 32'd146087;
   localparam logic [WET_WEIGHT_BITS-1:0]  WET_FULL          = 16'd32768;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RING_LENGTH = 2'd0,
      CSR_DELAY_SPAN  = 2'd1,
      CSR_WET_WEIGHT  = 2'd2,
      CSR_PHASE_STEP  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DELAY,
      ST_READ,
      ST_MIX,
      ST_OUT
   } state_type;

   typedef logic [63:0]        u64_type;
   typedef logic signed [63:0] s64_type;

   localparam u64_type PIH_Q30  = 64'd1686629713;
   localparam int      HALF     = SINE_SIZE / 2;
   localparam int      QUARTER  = SINE_SIZE / 4;
   localparam u64_type QUARTER_W = u64_type'(QUARTER);

   // One sine table entry in Q1.15. A quarter wave is evaluated by a Taylor
   // series to the x^13 term in Q30; this runs only at elaboration.
   function automatic logic signed [SINE_WIDTH-1:0] sine_entry(input int unsigned k);
      u64_type q;
      u64_type x;
      u64_type x2;
      u64_type term;
      u64_type r;
      s64_type s;
      q = (k < HALF) ? u64_type'(k) : u64_type'(k - HALF);
      if (q > u64_type'(QUARTER)) begin
         q = u64_type'(HALF) - q;
      end
      x    = (PIH_Q30 * q) / QUARTER_W;
      x2   = (x * x) >> 30;
      term = x;
      s    = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      s    = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      s    = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      s    = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      s    = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      s    = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      s    = s + $signed(term);
      if (s < 0) begin
         s = 64'sd0;
      end
      r = (($unsigned(s) * 64'd32768) + (64'd1 << 29)) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return (k < HALF) ? $signed(r[SINE_WIDTH-1:0]) : -$signed(r[SINE_WIDTH-1:0]);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lmc_ram.sv -----
// Generic single-clock RAM: one write port and one read port, registered read.
// No dependencies.
`default_nettype none

module lmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lfo_modulated_chorus.sv -----
// Top level of the sine-modulated chorus: control sequencer, datapath, registers.
// Depends on lmc_pkg and lmc_ram.
`default_nettype none

// Chorus with a sine oscillator sweeping the tap of a delay ring. Each sample
// passes from acceptance to a loaded result through these steps in order:
// acceptance with sine lookup and dry product, delay multiply, ring read, wet
// mix with ring write, then saturation into the output register once it is
// free. The steps are set by the ring RAM, which is read and then written
// once per sample through its single read and write ports. After reset the
// ring is zeroed by a clearing pass over all RING_DEPTH (2048) entries, during
// which req_stall stays high; configuration writes are taken at any time, but
// should only be made while no sample is in flight. The output register lets
// the next sample be accepted while a result still waits to be taken.
module lfo_modulated_chorus (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [lmc_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [lmc_pkg::SAMPLE_WIDTH-1:0]    rsp_sample_out,
   input  wire logic                                  csr_we,
   input  wire logic [lmc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [lmc_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   import lmc_pkg::*;

   localparam int Q_BITS = ACC_BITS - 15;
   localparam logic signed [Q_BITS-1:0] Y_MAX = Q_BITS'(2 ** (SAMPLE_WIDTH - 1) - 1);
   localparam logic signed [Q_BITS-1:0] Y_MIN = -Y_MAX - Q_BITS'(1);

   // Configuration registers.
   logic [RING_LENGTH_BITS-1:0] ring_length_ff;
   logic [DELAY_SPAN_BITS-1:0]  delay_span_ff;
   logic [WET_WEIGHT_BITS-1:0]  wet_weight_ff;
   logic [PHASE_STEP_BITS-1:0]  phase_step_ff;

   // Control and persistent state.
   state_type                 state_ff, state_in;
   logic [RING_ADDR_BITS-1:0] clear_cnt_ff;
   logic [RING_ADDR_BITS-1:0] wptr_ff;
   logic [PHASE_WIDTH-1:0]    phase_ff;
   logic                      rsp_valid_ff;

   // Per-sample datapath registers.
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [SINE_WIDTH-1:0]   sine_ff;
   logic signed [ACC_BITS-1:0]     dry_ff;
   logic signed [ACC_BITS-1:0]     acc_ff;
   logic [RING_ADDR_BITS-1:0]      delay_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;

   // Sine table, one constant per entry.
   logic signed [SINE_WIDTH-1:0] sine_rom [SINE_SIZE];

   for (genvar k = 0; k < SINE_SIZE; k++) begin : g_sine
      assign sine_rom[k] = sine_entry(k);
   end

   // Effective configuration after clamping.
   logic [31:0]               len_wide;
   logic [31:0]               span_wide;
   logic [31:0]               span_lim;
   logic [LEN_BITS-1:0]       len_eff;
   logic [RING_ADDR_BITS-1:0] span_eff;
   logic [WET_WEIGHT_BITS-1:0] wet_eff;
   logic [WET_WEIGHT_BITS-1:0] dry_w;

   always_comb begin
      len_wide  = 32'(ring_length_ff);
      if (len_wide < 32'd2) begin
         len_eff = LEN_BITS'(2);
      end else if (len_wide > 32'(RING_DEPTH)) begin
         len_eff = LEN_BITS'(RING_DEPTH);
      end else begin
         len_eff = LEN_BITS'(len_wide);
      end
      span_wide = 32'(delay_span_ff);
      span_lim  = 32'(len_eff) - 32'd1;
      span_eff  = RING_ADDR_BITS'((span_wide > span_lim) ? span_lim : span_wide);
      wet_eff   = (wet_weight_ff > WET_FULL) ? WET_FULL : wet_weight_ff;
      dry_w     = WET_WEIGHT_BITS'(17'd32768 - {1'b0, wet_eff});
   end

   // Datapath terms.
   logic                          req_accept;
   logic                          out_free;
   logic [RING_ADDR_BITS-1:0]     wptr_fixed;
   logic [SINE_WIDTH+RING_ADDR_BITS-1:0] delay_prod;
   logic [LEN_BITS-1:0]           wptr_l;
   logic [LEN_BITS-1:0]           delay_l;
   logic [LEN_BITS-1:0]           rd_l;
   logic [LEN_BITS-1:0]           wptr_next_l;
   logic signed [ACC_BITS-1:0]    dry_in;
   logic signed [ACC_BITS-1:0]    acc_in;
   logic signed [Q_BITS-1:0]      quot;
   logic signed [SAMPLE_WIDTH-1:0] y_sat;

   // RAM ports.
   logic                          ram_we;
   logic [RING_ADDR_BITS-1:0]     ram_waddr;
   logic [SAMPLE_WIDTH-1:0]       ram_wdata;
   logic                          ram_re;
   logic [RING_ADDR_BITS-1:0]     ram_raddr;
   logic [SAMPLE_WIDTH-1:0]       ram_rdata;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wptr_l      = LEN_BITS'(wptr_ff);
      delay_l     = LEN_BITS'(delay_ff);
      wptr_fixed  = (wptr_l >= len_eff) ? '0 : wptr_ff;
      // Offset binary form of the sine is sine + 32768.
      delay_prod  = {~sine_ff[SINE_WIDTH-1], sine_ff[SINE_WIDTH-2:0]} * span_eff;
      rd_l        = (wptr_l >= delay_l) ? (wptr_l - delay_l) : (wptr_l + len_eff - delay_l);
      ram_raddr   = rd_l[RING_ADDR_BITS-1:0];
      wptr_next_l = wptr_l + LEN_BITS'(1);
      dry_in      = req_sample_in * $signed({1'b0, dry_w});
      acc_in      = dry_ff + $signed(ram_rdata) * $signed({1'b0, wet_eff});
      // Division by 32768 truncated toward zero.
      quot        = Q_BITS'(acc_ff >>> 15);
      if (acc_ff[ACC_BITS-1] && (acc_ff[14:0] != 15'd0)) begin
         quot = quot + Q_BITS'(1);
      end
      if (quot > Y_MAX) begin
         y_sat = SAMPLE_WIDTH'(Y_MAX);
      end else if (quot < Y_MIN) begin
         y_sat = SAMPLE_WIDTH'(Y_MIN);
      end else begin
         y_sat = SAMPLE_WIDTH'(quot);
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = wptr_ff;
      ram_wdata = x_ff;
      ram_re    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clear_cnt_ff;
            ram_wdata = '0;
            if (clear_cnt_ff == RING_ADDR_BITS'(RING_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_DELAY;
            end
         end
         ST_DELAY: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            // The read of this sample's tap has completed, so the write is safe.
            ram_we   = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff   <= '0;
         wptr_ff        <= '0;
         phase_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         ring_length_ff <= RING_LENGTH_RESET;
         delay_span_ff  <= DELAY_SPAN_RESET;
         wet_weight_ff  <= WET_WEIGHT_RESET;
         phase_step_ff  <= PHASE_STEP_RESET;
      end else begin
         if (state_ff == ST_CLEAR) begin
            clear_cnt_ff <= clear_cnt_ff + RING_ADDR_BITS'(1);
         end
         if (req_accept) begin
            wptr_ff <= wptr_fixed;
         end
         if (state_ff == ST_OUT && out_free) begin
            wptr_ff      <= (wptr_next_l == len_eff) ? '0 : wptr_next_l[RING_ADDR_BITS-1:0];
            phase_ff     <= phase_ff + phase_step_ff;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_RING_LENGTH: ring_length_ff <= csr_data[RING_LENGTH_BITS-1:0];
               CSR_DELAY_SPAN:  delay_span_ff  <= csr_data[DELAY_SPAN_BITS-1:0];
               CSR_WET_WEIGHT:  wet_weight_ff  <= csr_data[WET_WEIGHT_BITS-1:0];
               CSR_PHASE_STEP:  phase_step_ff  <= csr_data[PHASE_STEP_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff    <= req_sample_in;
         sine_ff <= sine_rom[phase_ff[PHASE_WIDTH-1 -: SINE_ADDR_BITS]];
         dry_ff  <= dry_in;
      end
      if (state_ff == ST_DELAY) begin
         delay_ff <= delay_prod[SINE_WIDTH+RING_ADDR_BITS-1:SINE_WIDTH];
      end
      if (state_ff == ST_MIX) begin
         acc_ff <= acc_in;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_sample_ff <= y_sat;
      end
   end

   lmc_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // The pointer of a sample in flight always lies inside the ring in use.
   a_wptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELAY || state_ff == ST_READ || state_ff == ST_MIX ||
       state_ff == ST_OUT) |-> (LEN_BITS'(wptr_ff) < len_eff))
      else $error("write pointer outside the ring in use");

   // The tap address never leaves the ring in use.
   a_tap_in_ring: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (LEN_BITS'(ram_raddr) < len_eff))
      else $error("tap address outside the ring in use");

   // The ring is never written in the cycle its tap is read.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> !ram_we)
      else $error("ring write overlaps the tap read");

   // A new result appears only as the sequencer leaves its output step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid && rsp_stall)) |-> $past(state_ff == ST_OUT))
      else $error("result transaction without a finished sample");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for lfo_modulated_chorus: random and directed samples against
// an in-bench chorus predictor, with register sweeps and random handshake idling.
// Depends on lmc_pkg and the chorus RTL.
`timescale 1ns / 100ps

module tb_top;
   import lmc_pkg::*;

   localparam longint CYCLE_LIMIT   = 400000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int SAMPLES_PER_SETTING = 110;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // Stimulus and expected results.
   logic signed [SAMPLE_WIDTH-1:0] sample_queue [$];
   logic signed [SAMPLE_WIDTH-1:0] expected_mix [$];
   logic signed [SAMPLE_WIDTH-1:0] mix_want;
   int error_count = 0;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   longint cycle_count = 0;
   logic long_hold_req = 1'b0;
   logic long_hold_taken = 1'b0;
   int hold_left = 0;

   // Predictor state and its copy of the registers.
   int sine_table [SINE_SIZE];
   logic signed [SAMPLE_WIDTH-1:0] delay_line [RING_DEPTH];
   longint ring_wr_ptr;
   logic [PHASE_WIDTH-1:0] lfo_acc;
   logic [RING_LENGTH_BITS-1:0] cfg_ring_length = RING_LENGTH_RESET;
   logic [DELAY_SPAN_BITS-1:0] cfg_delay_span = DELAY_SPAN_RESET;
   logic [WET_WEIGHT_BITS-1:0] cfg_wet_weight = WET_WEIGHT_RESET;
   logic [PHASE_STEP_BITS-1:0] cfg_phase_step = PHASE_STEP_RESET;

   lfo_modulated_chorus i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Quarter-wave Taylor series in Q30, mirrored into a full Q1.15 table.
   function automatic void build_sine_table();
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] term;
      logic [63:0] rounded;
      longint sum;
      int unsigned q;
      int k;
      int n;
      for (k = 0; k < SINE_SIZE; k++) begin
         q = (k < SINE_SIZE / 2) ? k : k - SINE_SIZE / 2;
         if (q > SINE_SIZE / 4) begin
            q = SINE_SIZE / 2 - q;
         end
         ang = (HALF_PI_Q30 * 64'(q)) / 64'(SINE_SIZE / 4);
         ang_sq = (ang * ang) >> 30;
         term = ang;
         sum = longint'(ang);
         for (n = 1; n <= 6; n++) begin
            term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rounded = (64'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
         if (rounded > 64'd32767) begin
            rounded = 64'd32767;
         end
         sine_table[k] = (k < SINE_SIZE / 2) ? int'(rounded) : -int'(rounded);
      end
   endfunction

   // Computes the mixed sample for one accepted input and advances the ring and oscillator.
   function automatic logic signed [SAMPLE_WIDTH-1:0] chorus_mix(
      input logic signed [SAMPLE_WIDTH-1:0] dry);
      longint len;
      longint span;
      longint wet;
      longint sine_val;
      longint tap_delay;
      longint rd;
      longint acc;
      longint mixed;
      logic signed [SAMPLE_WIDTH-1:0] delayed;
      len = longint'(cfg_ring_length);
      span = longint'(cfg_delay_span);
      wet = longint'(cfg_wet_weight);
      if (len < 2) begin
         len = 2;
      end
      if (len > RING_DEPTH) begin
         len = RING_DEPTH;
      end
      if (span > len - 1) begin
         span = len - 1;
      end
      if (wet > 32768) begin
         wet = 32768;
      end
      // A ring that shrank under the pointer restarts at the first entry.
      if (ring_wr_ptr >= len) begin
         ring_wr_ptr = 0;
      end
      sine_val = sine_table[lfo_acc[PHASE_WIDTH-1 -: SINE_ADDR_BITS]];
      tap_delay = ((sine_val + 32768) * span) >> 16;
      rd = (ring_wr_ptr >= tap_delay) ? ring_wr_ptr - tap_delay
                                      : ring_wr_ptr + len - tap_delay;
      delayed = delay_line[rd % RING_DEPTH];
      acc = longint'(dry) * (32768 - wet) + longint'(delayed) * wet;
      mixed = acc / 32768;
      if (mixed > 32767) begin
         mixed = 32767;
      end
      if (mixed < -32768) begin
         mixed = -32768;
      end
      delay_line[ring_wr_ptr % RING_DEPTH] = dry;
      ring_wr_ptr = (ring_wr_ptr + 1) % len;
      lfo_acc = lfo_acc + cfg_phase_step;
      return mixed[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      logic signed [SAMPLE_WIDTH-1:0] s;
      case ($urandom_range(9))
         0: s = 16'h7FFF;
         1: s = 16'h8000;
         2: s = SAMPLE_WIDTH'($urandom_range(511)) - 16'sd256;
         default: s = SAMPLE_WIDTH'($urandom);
      endcase
      return s;
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RING_LENGTH: cfg_ring_length = value[RING_LENGTH_BITS-1:0];
         CSR_DELAY_SPAN:  cfg_delay_span = value[DELAY_SPAN_BITS-1:0];
         CSR_WET_WEIGHT:  cfg_wet_weight = value[WET_WEIGHT_BITS-1:0];
         CSR_PHASE_STEP:  cfg_phase_step = value[PHASE_STEP_BITS-1:0];
         default: begin
         end
      endcase
   endtask

   // Waits until every queued sample has been taken and every result has come back.
   task automatic settle();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || expected_mix.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_all(input logic [31:0] ring, input logic [31:0] span,
                          input logic [31:0] wet, input logic [31:0] step);
      settle();
      write_csr(CSR_RING_LENGTH, ring);
      write_csr(CSR_DELAY_SPAN, span);
      write_csr(CSR_WET_WEIGHT, wet);
      write_csr(CSR_PHASE_STEP, step);
      @(negedge clock);
   endtask

   task automatic random_setting();
      logic [31:0] ring;
      logic [31:0] span;
      logic [31:0] wet;
      case ($urandom_range(9))
         0: ring = $urandom_range(4095);
         1: ring = $urandom_range(2048, 1024);
         default: ring = $urandom_range(64, 2);
      endcase
      span = ($urandom_range(1) == 0) ? $urandom_range(2047) : $urandom_range(ring);
      wet = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(32768);
      set_all(ring, span, wet, $urandom);
   endtask

   // Sender: one transaction offered at a time, held while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_sample_in <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_mix.push_back(chorus_mix(req_sample_in));
         end
         if (!(req_valid && req_stall)) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_valid <= 1'b1;
               req_sample_in <= sample_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall, with one long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (long_hold_req && !long_hold_taken) begin
         rsp_stall <= 1'b1;
         hold_left <= 400;
         long_hold_taken <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_mix.size() == 0) begin
            $error("unexpected transaction: sample_out actual %0d", rsp_sample_out);
            error_count++;
         end else begin
            mix_want = expected_mix.pop_front();
            if (rsp_sample_out !== mix_want) begin
               $error("sample_out mismatch: expected %0d, actual %0d", mix_want,
                      rsp_sample_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int phase;
      int setting;
      int i;
      int drain_wait;
      build_sine_table();
      for (i = 0; i < RING_DEPTH; i++) begin
         delay_line[i] = '0;
      end
      ring_wr_ptr = 0;
      lfo_acc = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset values of the registers.
      tx_idle_pct = 12;
      rx_stall_pct = 69;
      @(negedge clock);
      sample_queue = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
      // Shortest ring with the span clamped and a fully wet mix; the pointer goes stale.
      set_all(2, 2047, 32768, 32'hFFFF_FFFF);
      sample_queue = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
      // Ring length below the minimum and a wet weight above full scale.
      set_all(0, 0, 65535, 0);
      sample_queue = '{16'h8000, 16'h7FFF, 16'h1234};
      // Ring length beyond the RAM depth, dry only.
      set_all(4095, 2047, 0, 32'h8000_0000);
      sample_queue = '{16'h7FFF, 16'h8000, 16'hC000, 16'h3FFF};
      set_all(16, 15, 1, 32'h4000_0000);
      sample_queue = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0F0F};

      // Random part: sender and receiver idling swapped, then none at all.
      for (phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 69 : 0;
         rx_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 12 : 0;
         for (setting = 0; setting < 3; setting++) begin
            random_setting();
            for (i = 0; i < SAMPLES_PER_SETTING; i++) begin
               sample_queue.push_back(random_sample());
            end
            if (phase == 2 && setting == 0) begin
               long_hold_req = 1'b1;
            end
         end
      end

      do @(negedge clock); while (sample_queue.size() != 0 || req_valid);
      drain_wait = 0;
      while (expected_mix.size() != 0 && drain_wait < 5000) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (10) @(posedge clock);
      if (expected_mix.size() != 0) begin
         $error("%0d expected sample_out values never arrived", expected_mix.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/lmc_pkg.sv
hdl/lmc_ram.sv
hdl/lfo_modulated_chorus.sv
test/tb_top.sv
